// ===== rtl/iavds_pkg.sv =====
// shared types, widths and constants for the idle air valve duty stepper
package iavds_pkg;

    localparam int RPM_W      = 14;
    localparam int DUTY_W     = 7;
    localparam int SEC_W      = 16;
    localparam int HOLD_W     = 8;
    localparam int WIN_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RPM    = 3'd0,
        CFG_DEFAULT_DUTY  = 3'd1,
        CFG_MIN_DUTY      = 3'd2,
        CFG_MAX_DUTY      = 3'd3,
        CFG_HOLD_SECONDS  = 3'd4,
        CFG_INCREASE_STEP = 3'd5,
        CFG_DECREASE_STEP = 3'd6
    } t_cfg_idx;

    localparam logic [RPM_W-1:0]  TARGET_RPM_RST    = 14'd1000;
    localparam logic [DUTY_W-1:0] DEFAULT_DUTY_RST  = 7'd60;
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST      = 7'd10;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST      = 7'd90;
    localparam logic [HOLD_W-1:0] HOLD_SECONDS_RST  = 8'd1;
    localparam logic [DUTY_W-1:0] INCREASE_STEP_RST = 7'd1;
    localparam logic [DUTY_W-1:0] DECREASE_STEP_RST = 7'd1;

    // speed margin for the large duty steps
    localparam logic [RPM_W-1:0] STEP_MARGIN = 14'd100;

    // floor(t*93/100) and floor(t*107/100) as a multiply by a scaled reciprocal,
    // exact for every 14-bit target
    localparam int                 SCALE_SHIFT = 24;
    localparam int                 MUL_W       = 25;
    localparam logic [MUL_W-1:0]   LEFT_MUL    = 25'd15602811;
    localparam logic [MUL_W-1:0]   RIGHT_MUL   = 25'd17951622;

    function automatic logic [WIN_W-1:0] win_edge(input logic [RPM_W-1:0] t,
                                                  input logic [MUL_W-1:0] mul);
        logic [RPM_W+MUL_W-1:0] prod;
        prod = {{MUL_W{1'b0}}, t} * {{RPM_W{1'b0}}, mul};
        return prod[SCALE_SHIFT +: WIN_W];
    endfunction

endpackage

// ===== rtl/iavds_if.sv =====
// handshake channels for speed samples and duty results
interface iavds_in_if
    import iavds_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [RPM_W-1:0]  rpm;
    logic [SEC_W-1:0]  now_seconds;
    logic              cranking;

    modport source (output valid, output rpm, output now_seconds, output cranking,
                    input ready);
    modport sink   (input valid, input rpm, input now_seconds, input cranking,
                    output ready);
endinterface

interface iavds_out_if
    import iavds_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink   (input valid, input duty, output ready);
endinterface

// ===== rtl/idle_air_valve_duty_stepper.sv =====
// Idle air valve duty stepper: top level
//
// i_in carries one speed sample per transfer (rpm, now_seconds, cranking);
// o_res returns exactly one duty per sample, in order. Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// no sample is in flight, which the block itself does not enforce; writes to unused
// indexes are dropped. The sample is registered in the input register, and the
// duty decision (a few compares, an add or subtract and the min/max clamp) runs
// combinationally on it and lands in the result register, together with the
// duty and timestamp state. One sample per cycle is sustained while the
// receiver takes every result; the duty state loop closes through that
// combinational decision. When the receiver stalls the result register holds,
// one more sample can wait in the input register, and then i_in.ready drops.
// Synchronous active-low reset empties both registers, loads the register
// reset values, sets the duty to 60 and the last change time to 0; ready is
// low during reset.
module idle_air_valve_duty_stepper
    import iavds_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    iavds_in_if.sink              i_in,
    iavds_out_if.source           o_res
);

    // configuration
    logic [WIN_W-1:0]  r_left;
    logic [WIN_W-1:0]  r_right;
    logic [DUTY_W-1:0] r_default_duty;
    logic [DUTY_W-1:0] r_min_duty;
    logic [DUTY_W-1:0] r_max_duty;
    logic [HOLD_W-1:0] r_hold_seconds;
    logic [DUTY_W-1:0] r_increase_step;
    logic [DUTY_W-1:0] r_decrease_step;

    // input register
    logic              r_s1_valid;
    logic [RPM_W-1:0]  r_rpm;
    logic [SEC_W-1:0]  r_now;
    logic              r_cranking;

    // state and result register
    logic [DUTY_W-1:0]    r_duty;
    logic [TIME_BITS-1:0] r_last_change;
    logic                 r_out_valid;
    logic [DUTY_W-1:0]    r_out_duty;

    logic                 accept;
    logic                 advance;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [RPM_W+3:0]     rpm_x10;
    logic [WIN_W+2:0]     left_x7;
    logic [WIN_W:0]       rpm_w;
    logic                 hold_active;
    logic                 apply;
    logic signed [8:0]    cur9;
    logic signed [8:0]    wanted;
    logic signed [8:0]    clamped;
    logic [DUTY_W-1:0]    n_duty;
    logic                 changed;

    assign advance    = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || advance);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left          <= win_edge(TARGET_RPM_RST, LEFT_MUL);
            r_right         <= win_edge(TARGET_RPM_RST, RIGHT_MUL);
            r_default_duty  <= DEFAULT_DUTY_RST;
            r_min_duty      <= MIN_DUTY_RST;
            r_max_duty      <= MAX_DUTY_RST;
            r_hold_seconds  <= HOLD_SECONDS_RST;
            r_increase_step <= INCREASE_STEP_RST;
            r_decrease_step <= DECREASE_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_RPM: begin
                    r_left       <= win_edge(i_cfg_data[RPM_W-1:0], LEFT_MUL);
                    r_right      <= win_edge(i_cfg_data[RPM_W-1:0], RIGHT_MUL);
                end
                CFG_DEFAULT_DUTY:  r_default_duty  <= i_cfg_data[DUTY_W-1:0];
                CFG_MIN_DUTY:      r_min_duty      <= i_cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY:      r_max_duty      <= i_cfg_data[DUTY_W-1:0];
                CFG_HOLD_SECONDS:  r_hold_seconds  <= i_cfg_data[HOLD_W-1:0];
                CFG_INCREASE_STEP: r_increase_step <= i_cfg_data[DUTY_W-1:0];
                CFG_DECREASE_STEP: r_decrease_step <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rpm      <= i_in.rpm;
            r_now      <= i_in.now_seconds;
            r_cranking <= i_in.cranking;
        end
    end

    // timestamp at the state width
    generate
        if (TIME_BITS > SEC_W) begin : g_now_ext
            assign now_t = {{(TIME_BITS-SEC_W){1'b0}}, r_now};
        end else if (TIME_BITS == SEC_W) begin : g_now_same
            assign now_t = r_now;
        end else begin : g_now_trunc
            assign now_t = r_now[TIME_BITS-1:0];
        end
    endgenerate

    assign elapsed     = now_t - r_last_change;
    assign hold_active = elapsed < {{(TIME_BITS-HOLD_W){1'b0}}, r_hold_seconds};
    assign rpm_x10     = {1'b0, r_rpm, 3'b000} + {3'b000, r_rpm, 1'b0};
    assign left_x7     = {r_left, 3'b000} - {3'b000, r_left};
    assign rpm_w       = {2'b00, r_rpm};
    assign cur9        = $signed({2'b00, r_duty});

    always_comb begin
        apply  = 1'b1;
        wanted = $signed({2'b00, r_default_duty});
        if ((r_rpm == '0) || r_cranking) begin
            wanted = $signed({2'b00, r_default_duty});
        end else if ({1'b0, rpm_x10} < {1'b0, left_x7}) begin
            wanted = $signed({2'b00, r_default_duty});
        end else if (hold_active) begin
            apply = 1'b0;
        end else if ((rpm_w > {1'b0, r_left}) && (rpm_w < {1'b0, r_right})) begin
            apply = 1'b0;
        end else if (rpm_w >= ({1'b0, r_right} + {2'b00, STEP_MARGIN})) begin
            wanted = cur9 - $signed({2'b00, r_decrease_step});
        end else if (rpm_w >= {1'b0, r_right}) begin
            wanted = cur9 - 9'sd1;
        end else if ((rpm_w + {2'b00, STEP_MARGIN}) < {1'b0, r_left}) begin
            wanted = cur9 + $signed({2'b00, r_increase_step});
        end else begin
            wanted = cur9 + 9'sd1;
        end
    end

    // lower bound first, upper bound wins when they cross
    always_comb begin
        clamped = wanted;
        if (clamped < $signed({2'b00, r_min_duty})) begin
            clamped = $signed({2'b00, r_min_duty});
        end
        if (clamped > $signed({2'b00, r_max_duty})) begin
            clamped = $signed({2'b00, r_max_duty});
        end
    end

    assign n_duty  = apply ? clamped[DUTY_W-1:0] : r_duty;
    assign changed = apply && (clamped != cur9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty        <= DEFAULT_DUTY_RST;
            r_last_change <= '0;
        end else if (advance) begin
            r_duty <= n_duty;
            if (changed) begin
                r_last_change <= now_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_duty <= n_duty;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.duty  = r_out_duty;

endmodule

// ===== rtl/iavds_chk.sv =====
// port-level checks for the idle air valve duty stepper, bound to the top level
module iavds_chk
    import iavds_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_out_duty
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_duty)))
        else $error("result changed or dropped while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a new result needs an input transfer that went through the input and result registers
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching input transfer");

    // no input transfer while in reset
    a_rst_noready: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_in_ready)
        else $error("input ready during reset");

endmodule

bind idle_air_valve_duty_stepper iavds_chk u_iavds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_duty  (o_res.duty)
);

// ===== sim/idle_air_valve_duty_stepper_tb.sv =====
// self-checking testbench for the idle air valve duty stepper
`timescale 1ns / 100ps

module idle_air_valve_duty_stepper_tb;
    import iavds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 13;
    localparam int PHASE_ITEMS    = 98;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic [SEC_W-1:0] now;
        logic             crank;
    } t_speed_sample;

    typedef struct {
        logic [RPM_W-1:0]  tgt;
        logic [DUTY_W-1:0] dflt;
        logic [DUTY_W-1:0] dmin;
        logic [DUTY_W-1:0] dmax;
        logic [HOLD_W-1:0] hold;
        logic [DUTY_W-1:0] inc;
        logic [DUTY_W-1:0] dec;
    } t_valve_setting;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    iavds_in_if  sample_ch ();
    iavds_out_if duty_ch ();

    idle_air_valve_duty_stepper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch.sink),
        .o_res      (duty_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block's registers and duty state
    t_valve_setting    shadow;
    logic [DUTY_W-1:0] duty_now;
    logic [SEC_W-1:0]  last_change;

    t_speed_sample     pending_samples[$];
    logic [DUTY_W-1:0] duty_expected[$];

    int  n_queued;
    int  n_checked;
    int  n_changes;
    int  errors;
    int  idle_cycles;
    int  send_gap;
    int  recv_stall;
    bit  in_taken;
    bit  calm;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DUTY_W-1:0] step_valve_duty(logic [RPM_W-1:0] rpm,
                                                          logic [SEC_W-1:0] now,
                                                          logic crank);
        int               left;
        int               right;
        int               r;
        int               want;
        bit               adjust;
        logic [SEC_W-1:0] since;
        left   = (int'(shadow.tgt) * 93) / 100;
        right  = (int'(shadow.tgt) * 107) / 100;
        r      = int'(rpm);
        adjust = 1'b1;
        want   = int'(duty_now);
        if (rpm == '0 || crank) begin
            want = int'(shadow.dflt);
        end else if (10 * r < 7 * left) begin
            want = int'(shadow.dflt);
        end else begin
            since = now - last_change;
            if (since < shadow.hold)
                adjust = 1'b0;
            else if (r > left && r < right)
                adjust = 1'b0;
            else if (r >= right + 100)
                want = int'(duty_now) - int'(shadow.dec);
            else if (r >= right)
                want = int'(duty_now) - 1;
            else if (r + 100 < left)
                want = int'(duty_now) + int'(shadow.inc);
            else
                want = int'(duty_now) + 1;
        end
        if (adjust) begin
            // lower clamp first, so crossed bounds end at max
            if (want < int'(shadow.dmin))
                want = int'(shadow.dmin);
            if (want > int'(shadow.dmax))
                want = int'(shadow.dmax);
            if (want != int'(duty_now)) begin
                last_change = now;
                n_changes++;
            end
            duty_now = want[DUTY_W-1:0];
        end
        return duty_now;
    endfunction

    // input side: hold the sample until its transfer, then pick a gap; result side: random ready stalls
    always @(negedge i_clk) begin
        t_speed_sample s;
        if (!sample_ch.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                sample_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s = pending_samples.pop_front();
                sample_ch.rpm         <= s.rpm;
                sample_ch.now_seconds <= s.now;
                sample_ch.cranking    <= s.crank;
                sample_ch.valid       <= 1'b1;
                send_gap              <= calm ? 0 : rand_gap();
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
        if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            duty_ch.ready <= 1'b0;
        end else begin
            duty_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                recv_stall <= rand_gap();
        end
    end

    always @(posedge i_clk) begin
        logic [DUTY_W-1:0] exp_duty;
        bit                moved;
        moved    = 1'b0;
        in_taken <= sample_ch.valid && sample_ch.ready;
        // check before predicting so a stray result cannot match a fresh sample
        if (i_rst_n && duty_ch.valid && duty_ch.ready) begin
            moved = 1'b1;
            if (duty_expected.size() == 0) begin
                $display("%0t: duty %0d with no sample pending", $time, duty_ch.duty);
                errors++;
            end else begin
                exp_duty = duty_expected.pop_front();
                if (duty_ch.duty !== exp_duty) begin
                    $display("%0t: duty mismatch, expected %0d, got %0d",
                             $time, exp_duty, duty_ch.duty);
                    errors++;
                end
                n_checked++;
            end
        end
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            moved = 1'b1;
            duty_expected.push_back(step_valve_duty(sample_ch.rpm, sample_ch.now_seconds,
                                                    sample_ch.cranking));
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TARGET_RPM:    shadow.tgt  = data[RPM_W-1:0];
            CFG_DEFAULT_DUTY:  shadow.dflt = data[DUTY_W-1:0];
            CFG_MIN_DUTY:      shadow.dmin = data[DUTY_W-1:0];
            CFG_MAX_DUTY:      shadow.dmax = data[DUTY_W-1:0];
            CFG_HOLD_SECONDS:  shadow.hold = data[HOLD_W-1:0];
            CFG_INCREASE_STEP: shadow.inc  = data[DUTY_W-1:0];
            CFG_DECREASE_STEP: shadow.dec  = data[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_valve_setting s, input bit junk);
        logic [CFG_DATA_W-1:0] hi;
        hi = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_TARGET_RPM, s.tgt);
        write_reg(CFG_DEFAULT_DUTY, {hi[CFG_DATA_W-1:DUTY_W], s.dflt});
        write_reg(CFG_MIN_DUTY, {hi[CFG_DATA_W-1:DUTY_W], s.dmin});
        write_reg(CFG_MAX_DUTY, {hi[CFG_DATA_W-1:DUTY_W], s.dmax});
        write_reg(CFG_HOLD_SECONDS, {hi[CFG_DATA_W-1:HOLD_W], s.hold});
        write_reg(CFG_INCREASE_STEP, {hi[CFG_DATA_W-1:DUTY_W], s.inc});
        write_reg(CFG_DECREASE_STEP, {hi[CFG_DATA_W-1:DUTY_W], s.dec});
        // unused index must leave every register alone
        if (junk)
            write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input int rpm, input int now, input bit crank);
        t_speed_sample s;
        s.rpm   = rpm[RPM_W-1:0];
        s.now   = now[SEC_W-1:0];
        s.crank = crank;
        pending_samples.push_back(s);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_valve_setting s;
        int             tnow;
        int             span;
        int             v;
        int             r;
        bit             junk;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.rpm         = '0;
        sample_ch.now_seconds = '0;
        sample_ch.cranking    = 1'b0;
        duty_ch.ready         = 1'b0;
        n_queued  = 0;
        n_checked = 0;
        n_changes = 0;
        errors    = 0;
        idle_cycles = 0;
        send_gap  = 0;
        recv_stall = 0;
        in_taken  = 1'b0;
        calm      = 1'b0;

        shadow.tgt  = TARGET_RPM_RST;
        shadow.dflt = DEFAULT_DUTY_RST;
        shadow.dmin = MIN_DUTY_RST;
        shadow.dmax = MAX_DUTY_RST;
        shadow.hold = HOLD_SECONDS_RST;
        shadow.inc  = INCREASE_STEP_RST;
        shadow.dec  = DECREASE_STEP_RST;
        duty_now    = DEFAULT_DUTY_RST;
        last_change = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: window 930..1070, duty 60, hold 1 s
        add_sample(0, 0, 0);          // stalled
        add_sample(1000, 0, 1);       // cranking
        add_sample(16383, 5, 0);      // far above: large step down
        add_sample(16383, 5, 0);      // inside hold time
        add_sample(1000, 7, 0);       // inside the window
        add_sample(1070, 8, 0);       // right edge: step of 1 down
        add_sample(1169, 9, 0);       // just inside upper margin
        add_sample(1170, 10, 0);      // upper margin reached
        add_sample(930, 11, 0);       // left edge: step of 1 up
        add_sample(830, 12, 0);       // just inside lower margin
        add_sample(829, 13, 0);       // beyond lower margin
        add_sample(651, 14, 0);       // at the very-low threshold, not yet very low
        add_sample(650, 15, 0);       // very low: default duty
        add_sample(16383, 16, 0);
        add_sample(16383, 65535, 0);  // top of the seconds range
        add_sample(16383, 0, 0);      // seconds wrap
        add_sample(16383, 0, 1);      // back to default
        add_sample(2000, 200, 0);
        add_sample(2000, 100, 0);     // timestamp going backwards
        add_sample(1, 65535, 0);
        add_sample(8192, 32768, 1);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            s.tgt  = $urandom_range(700, 3000);
            s.dflt = $urandom_range(20, 80);
            s.dmin = $urandom_range(0, 30);
            s.dmax = $urandom_range(60, 100);
            s.hold = $urandom_range(0, 4);
            s.inc  = $urandom_range(0, 15);
            s.dec  = $urandom_range(0, 15);
            case (p)
                1: begin
                    s.tgt  = 0;
                    s.hold = 0;
                end
                2: begin
                    s.tgt  = 16383;
                    s.dmin = 0;
                    s.dmax = 100;
                    s.inc  = 100;
                    s.dec  = 100;
                    s.hold = 255;
                end
                3: begin
                    // crossed clamp bounds
                    s.dmin = 90;
                    s.dmax = 20;
                end
                4: begin
                    s.dflt = 127;
                    s.dmin = 0;
                    s.dmax = 127;
                    s.inc  = 127;
                    s.dec  = 127;
                    s.hold = 0;
                end
                5: begin
                    s.dflt = 0;
                    s.dmin = 0;
                    s.dmax = 0;
                    s.inc  = 0;
                    s.dec  = 0;
                end
                6: begin
                    s.dflt = 100;
                    s.dmin = 100;
                    s.dmax = 100;
                    s.tgt  = 1;
                end
                7: begin
                    s.tgt = $urandom_range(0, 16383);
                    s.hold = $urandom_range(0, 255);
                end
                default: ;
            endcase
            junk = (p % 3 == 2) || (p == 4);
            apply_setting(s, junk);
            calm = (p % 4 == 1);

            tnow = $urandom;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // plausible idle: speed near the target, time moving on
                    tnow += $urandom_range(0, int'(shadow.hold) + 2);
                    span = int'(shadow.tgt) / 4 + 150;
                    v = int'(shadow.tgt) - span + $urandom_range(0, 2 * span);
                    if (v < 1)
                        v = 1;
                    if (v > 16383)
                        v = 16383;
                    add_sample(v, tnow, 0);
                end else if (r < 78) begin
                    tnow += $urandom_range(0, 3);
                    add_sample($urandom_range(0, 16383), tnow, 1);
                end else if (r < 83) begin
                    tnow += $urandom_range(0, 3);
                    add_sample(0, tnow, 0);
                end else if (r < 90) begin
                    tnow -= $urandom_range(1, 500);
                    add_sample($urandom_range(1, 16383), tnow, 0);
                end else begin
                    add_sample($urandom_range(0, 16383), $urandom, $urandom_range(0, 1));
                end
            end
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        errors += duty_expected.size();
        $display("checked %0d duty results over %0d register settings", n_checked,
                 N_PHASES + 1);
        $display("predicted %0d duty changes, %0d errors", n_changes, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
